// ----- src/srpm_pkg.sv -----
// shared types, constants and control store for the simplex refinement point matrix unit
// no dependencies; imported by srpm_vertex_unit and the top level
`default_nettype none

package srpm_pkg;

  // packed path width and the group layout that follows from it
  localparam int CODE_WIDTH  = 32;
  localparam int GROUP_BITS  = 5;
  localparam int NUM_GROUPS  = (CODE_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
  localparam int PAD_W       = NUM_GROUPS * GROUP_BITS;
  localparam int GRP_CNT_W   = $clog2(NUM_GROUPS + 1);
  localparam int GRP_IDX_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // stream widths
  localparam int IN_W        = 32;
  localparam int IN_USED     = (CODE_WIDTH < IN_W) ? CODE_WIDTH : IN_W;
  localparam int VNUM_W      = 3;
  localparam int OUT_CRD_W   = 8;
  localparam int OUT_FIELD_W = VNUM_W + 4 * OUT_CRD_W;
  localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

  // one fraction bit per level keeps every midpoint exact
  localparam int OUT_FRAC    = 7;
  localparam int FRAC_BITS   = (NUM_GROUPS > OUT_FRAC) ? NUM_GROUPS : OUT_FRAC;
  localparam int CRD_W       = FRAC_BITS + 1;
  localparam int NUM_VTX     = 5;
  localparam logic [VNUM_W-1:0] LAST_VTX = VNUM_W'(NUM_VTX - 1);

  typedef logic [CRD_W-1:0] coord_t;
  typedef coord_t [3:0]     vtx_t;
  typedef vtx_t [NUM_VTX-1:0] vtx_arr_t;

  // nibble codes
  localparam logic [3:0] NIB_C1_FIRST = 4'd1;
  localparam logic [3:0] NIB_C1_LAST  = 4'd4;
  localparam logic [3:0] NIB_C2_T0    = 4'd11;
  localparam logic [3:0] NIB_C2_T1    = 4'd12;
  localparam logic [3:0] NIB_C2_T2    = 4'd13;
  localparam logic [3:0] NIB_C2_T3    = 4'd14;

  // datapath control from the sequencer
  typedef struct packed {
    logic       init;
    logic       step;
    logic [3:0] nib;
    logic       sw;
  } srpm_ctl_t;

  // sequencer steps
  localparam logic [1:0] STEP_IDLE  = 2'd0;
  localparam logic [1:0] STEP_LEVEL = 2'd1;
  localparam logic [1:0] STEP_EMIT  = 2'd2;

  // jump conditions
  localparam logic [1:0] COND_IN_BEAT     = 2'd0;
  localparam logic [1:0] COND_LEVELS_DONE = 2'd1;
  localparam logic [1:0] COND_EMIT_LAST   = 2'd2;
  localparam logic [1:0] COND_ALWAYS      = 2'd3;

  typedef struct packed {
    logic       accept_en;
    logic       level_en;
    logic       emit_en;
    logic [1:0] cond;
    logic [1:0] target;
  } ucode_t;

  // control store: stay on a step until its condition holds, then jump
  function automatic ucode_t ucode_rom(input logic [1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      STEP_IDLE: begin
        w.accept_en = 1'b1;
        w.cond      = COND_IN_BEAT;
        w.target    = STEP_LEVEL;
      end
      STEP_LEVEL: begin
        w.level_en = 1'b1;
        w.cond     = COND_LEVELS_DONE;
        w.target   = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit_en = 1'b1;
        w.cond    = COND_EMIT_LAST;
        w.target  = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic nib_supported(input logic [3:0] nib);
    return ((nib >= NIB_C1_FIRST) && (nib <= NIB_C1_LAST)) ||
           ((nib >= NIB_C2_T0) && (nib <= NIB_C2_T3));
  endfunction

endpackage

`default_nettype wire

// ----- src/srpm_vertex_unit.sv -----
// vertex register file and the one-level midpoint / shift / swap datapath
// depends on srpm_pkg
`default_nettype none

module srpm_vertex_unit
  import srpm_pkg::*;
(
  input  wire logic      clk,
  input  wire srpm_ctl_t ctl,
  output vtx_arr_t       vtx
);

  vtx_arr_t vtx_r;
  vtx_arr_t vtx_nxt;

  always_comb begin
    vtx_t   a0, a4, mid, n0, n1, n2, n3, n4;
    logic   child1, tag_last, fin_swap;
    logic [CRD_W:0] sum;
    vtx_nxt  = vtx_r;
    child1   = (ctl.nib >= NIB_C1_FIRST) && (ctl.nib <= NIB_C1_LAST);
    tag_last = (ctl.nib == NIB_C2_T2) || (ctl.nib == NIB_C2_T3);
    a0 = ctl.sw ? vtx_r[4] : vtx_r[0];
    a4 = ctl.sw ? vtx_r[0] : vtx_r[4];
    for (int i = 0; i < 4; i++) begin
      sum    = {1'b0, a0[i]} + {1'b0, a4[i]};
      mid[i] = sum[CRD_W:1];
    end
    n1 = mid;
    if (child1) begin
      n0 = a0;       n2 = vtx_r[1]; n3 = vtx_r[2]; n4 = vtx_r[3];
    end else if (ctl.nib == NIB_C2_T0) begin
      n0 = a4;       n2 = vtx_r[3]; n3 = vtx_r[2]; n4 = vtx_r[1];
    end else if (ctl.nib == NIB_C2_T1) begin
      n0 = a4;       n2 = vtx_r[1]; n3 = vtx_r[3]; n4 = vtx_r[2];
    end else begin
      n0 = a4;       n2 = vtx_r[1]; n3 = vtx_r[2]; n4 = vtx_r[3];
    end
    // the last two tags swap again on the set bit, the others on the clear bit
    fin_swap = tag_last ? ctl.sw : !ctl.sw;
    if (ctl.init) begin
      for (int k = 0; k < NUM_VTX; k++) begin
        for (int i = 0; i < 4; i++) begin
          vtx_nxt[k][i] = (k >= 1 && i == k - 1) ? coord_t'(1 << FRAC_BITS) : '0;
        end
      end
    end else if (ctl.step && nib_supported(ctl.nib)) begin
      vtx_nxt[0] = fin_swap ? n4 : n0;
      vtx_nxt[1] = n1;
      vtx_nxt[2] = n2;
      vtx_nxt[3] = n3;
      vtx_nxt[4] = fin_swap ? n0 : n4;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r <= vtx_nxt;
  end

  assign vtx = vtx_r;

endmodule

`default_nettype wire

// ----- src/simplex_refinement_point_matrix_unit.sv -----
// top level: stream ports, microcoded sequencer, path group store and result register
// depends on srpm_pkg and srpm_vertex_unit
`default_nettype none

// Takes one packed refinement path per input beat and returns five result beats, one per
// vertex of the child 4-simplex, vertex 0 first, with tlast on vertex 4. An item is accepted
// in the idle step, the level step then works through the used 5-bit groups, and the emit
// step sends the result beats, waiting while the output side stalls. The level step of the
// sequencer applies one group per cycle, and a single output register carries the results.
// A path with an unsupported code in any used group (zero included) returns all-zero
// coordinates with tuser set. A new path is taken while the last result beat of the previous
// one still waits in the output register.
module simplex_refinement_point_matrix_unit
  import srpm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // transform_code
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // vertex_number, coord_x, coord_y, coord_z, coord_w
  output logic                  out_tuser,  // bad_code
  output logic                  out_tlast   // last_vertex
);

  logic [1:0]           pc_r, pc_nxt;
  logic [GRP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 bad_r, bad_nxt;
  logic [VNUM_W-1:0]    vidx_r, vidx_nxt;
  logic [GROUP_BITS-1:0] grp_r [NUM_GROUPS];

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;
  logic                 out_user_r;
  logic                 out_last_r;

  ucode_t               uw;
  srpm_ctl_t            ctl;
  vtx_arr_t             vtx;
  logic [PAD_W-1:0]     code_pad;
  logic [GRP_CNT_W-1:0] used_cnt;
  logic [GROUP_BITS-1:0] cur_grp;
  logic                 in_beat, levels_done, emit_fire, cond_hit;

  assign uw        = ucode_rom(pc_r);
  assign in_tready = uw.accept_en;
  assign in_beat   = in_tvalid && uw.accept_en;
  assign code_pad  = PAD_W'(in_tdata[IN_USED-1:0]);

  // used groups reach up to the highest nonzero one
  always_comb begin
    used_cnt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (code_pad[g*GROUP_BITS +: GROUP_BITS] != '0) begin
        used_cnt = GRP_CNT_W'(g + 1);
      end
    end
  end

  assign cur_grp     = grp_r[GRP_IDX_W'(cnt_r - 1'b1)];
  assign levels_done = (cnt_r == '0) || bad_r;
  assign emit_fire   = uw.emit_en && (!out_valid_r || out_tready);

  always_comb begin
    ctl.init = in_beat;
    ctl.step = uw.level_en && !levels_done;
    ctl.nib  = cur_grp[3:0];
    ctl.sw   = cur_grp[4];
  end

  srpm_vertex_unit u_vtx (
    .clk (clk),
    .ctl (ctl),
    .vtx (vtx)
  );

  always_comb begin
    unique case (uw.cond)
      COND_IN_BEAT:     cond_hit = in_beat;
      COND_LEVELS_DONE: cond_hit = levels_done;
      COND_EMIT_LAST:   cond_hit = emit_fire && (vidx_r == LAST_VTX);
      COND_ALWAYS:      cond_hit = 1'b1;
      default:          cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = cond_hit ? uw.target : pc_r;
    cnt_nxt  = cnt_r;
    bad_nxt  = bad_r;
    vidx_nxt = vidx_r;
    if (in_beat) begin
      cnt_nxt  = used_cnt;
      bad_nxt  = 1'b0;
      vidx_nxt = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!nib_supported(ctl.nib)) begin
        bad_nxt = 1'b1;
      end
    end else if (emit_fire) begin
      vidx_nxt = vidx_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      vidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
      vidx_r      <= vidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_r[g] <= code_pad[g*GROUP_BITS +: GROUP_BITS];
      end
    end
  end

  // result beat payload
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[VNUM_W-1:0] = vidx_r;
    for (int i = 0; i < 4; i++) begin
      out_data_nxt[VNUM_W + i*OUT_CRD_W +: OUT_CRD_W] = bad_r ? '0 :
        OUT_CRD_W'(vtx[vidx_r][i] >> (FRAC_BITS - OUT_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= bad_r;
      out_last_r <= (vidx_r == LAST_VTX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
